[src/socket_buffer_allocator_top_macros.svh]
// Assertion helpers for the buffer allocator.
`ifndef SOCKET_BUFFER_ALLOCATOR_TOP_MACROS_SVH
`define SOCKET_BUFFER_ALLOCATOR_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SBA_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("allocator check failed");

// Next-cycle implication, checked out of reset.
`define SBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("allocator check failed");

`endif

[src/sba_pkg.sv]
package sba_pkg;

    // request kinds
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    // result status codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_NONE     = 2'd1;
    localparam logic [1:0] STAT_ALREADY  = 2'd2;

    // configuration register indexes
    localparam logic CFG_POOL_IN_USE = 1'b0;
    localparam logic CFG_SMALL_LIMIT = 1'b1;

    // field widths
    localparam int COUNT_W = 6;
    localparam int SIZE_W  = 16;

    // write command to a bank of busy flags
    typedef struct packed {
        logic we;
        logic val;
    } t_flag_cmd;

endpackage

[src/sba_wrap.sv]
// Shared compare-and-subtract step: reduces a value by the modulus once.
module sba_wrap #(
    parameter int VW = 6
) (
    input  logic [VW-1:0]                i_val,
    input  logic [sba_pkg::COUNT_W-1:0]  i_mod,
    output logic [VW-1:0]                o_val,
    output logic                         o_ge
);
    import sba_pkg::*;

    localparam int WW = (VW > COUNT_W) ? VW : COUNT_W;

    logic [WW-1:0] w_a;
    logic [WW-1:0] w_m;
    logic [WW-1:0] w_diff;

    assign w_a    = WW'(i_val);
    assign w_m    = WW'(i_mod);
    assign w_diff = w_a - w_m;
    assign o_ge   = (w_a >= w_m);
    assign o_val  = o_ge ? VW'(w_diff) : i_val;
endmodule

[src/sba_pool_flags.sv]
// Busy flags of the shared pool, one read/write address per cycle.
module sba_pool_flags #(
    parameter int POOL_DEPTH = 32,
    parameter int PW         = 5
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [PW-1:0]        i_addr,
    input  sba_pkg::t_flag_cmd   i_cmd,
    output logic                 o_busy
);
    import sba_pkg::*;

    logic r_busy [POOL_DEPTH];

    // flags clear at reset; a write hits the addressed entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < POOL_DEPTH; k++) begin
                r_busy[k] <= 1'b0;
            end
        end else if (i_cmd.we && (int'(i_addr) < POOL_DEPTH)) begin
            r_busy[i_addr] <= i_cmd.val;
        end
    end

    assign o_busy = (int'(i_addr) < POOL_DEPTH) ? r_busy[i_addr] : 1'b0;
endmodule

[src/sba_small_flags.sv]
// Busy flags of the per-socket small receive and transmit buffers.
module sba_small_flags #(
    parameter int SOCKETS = 16,
    parameter int SW      = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [SW-1:0]        i_addr,
    input  logic                 i_dir,
    input  sba_pkg::t_flag_cmd   i_cmd,
    output logic                 o_busy
);
    import sba_pkg::*;

    logic r_rx_busy [SOCKETS];
    logic r_tx_busy [SOCKETS];
    logic w_in_range;

    assign w_in_range = (int'(i_addr) < SOCKETS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SOCKETS; k++) begin
                r_rx_busy[k] <= 1'b0;
                r_tx_busy[k] <= 1'b0;
            end
        end else if (i_cmd.we && w_in_range) begin
            if (i_dir) begin
                r_tx_busy[i_addr] <= i_cmd.val;
            end else begin
                r_rx_busy[i_addr] <= i_cmd.val;
            end
        end
    end

    always_comb begin
        o_busy = 1'b0;
        if (w_in_range) begin
            o_busy = i_dir ? r_tx_busy[i_addr] : r_rx_busy[i_addr];
        end
    end
endmodule

[src/socket_buffer_allocator_top.sv]
// Socket buffer allocator. Each request word (allocate or free) yields one result
// word. A free, or an allocate served by the socket's own small buffer or
// failing on an empty pool, passes through the exec state to the response state,
// which registers the result word. An allocate that searches the shared pool goes
// from exec through a normalise state, taking k wrap steps to bring the starting
// position below n (n = pool entries in use; k is 0 or 1, more only right after n
// was made smaller), and then a search state that visits s entries (1 to n). The
// search walks one entry a cycle through a single compare-subtract wrap unit. The
// response state waits while an earlier result word is held by the output. The
// input is not ready while a request is in progress. Writing the in-use count
// clamps it to 1..POOL_DEPTH (at most 63) and resets the free count to it.
module socket_buffer_allocator_top #(
    parameter int SOCKETS    = 16,
    parameter int POOL_DEPTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // tdata: socket[3:0], direction[4], request_size[20:5],
    //        handle_is_shared[21], handle_pool_index[26:22], zero fill
    input  logic [31:0]                   s_axis_tdata,
    // tuser: mode[0]
    input  logic [0:0]                    s_axis_tuser,
    // result stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // tdata: status[1:0], granted_is_shared[2], granted_pool_index[7:3],
    //        shared_free_count[13:8], zero fill
    output logic [15:0]                   m_axis_tdata,
    // configuration writes
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [sba_pkg::SIZE_W-1:0]    i_cfg_data
);
    import sba_pkg::*;

    localparam int PW      = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int SW      = (SOCKETS > 1) ? $clog2(SOCKETS) : 1;
    localparam int MAX_USE = (POOL_DEPTH < 63) ? POOL_DEPTH : 63;
    localparam logic [COUNT_W-1:0] MAX_USE_W = COUNT_W'(MAX_USE);
    // in-use count after reset: 32, clamped to the pool size
    localparam int RESET_USE = (POOL_DEPTH < 32) ? POOL_DEPTH : 32;
    localparam logic [COUNT_W-1:0] RESET_USE_W = COUNT_W'(RESET_USE);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_EXEC   = 5'b00010,
        ST_NORM   = 5'b00100,
        ST_SEARCH = 5'b01000,
        ST_RESP   = 5'b10000
    } t_state;

    t_state r_state, n_state;

    // captured request
    logic               r_mode;
    logic [3:0]         r_sock;
    logic               r_dir;
    logic [SIZE_W-1:0]  r_size;
    logic               r_shared;
    logic [4:0]         r_pidx;

    // configuration and allocator state
    logic [COUNT_W-1:0] r_in_use, n_in_use;
    logic [SIZE_W-1:0]  r_limit, n_limit;
    logic [COUNT_W-1:0] r_free, n_free;
    logic [PW-1:0]      r_sp, n_sp;
    logic [PW:0]        r_cand, n_cand;
    logic [COUNT_W-1:0] r_iter, n_iter;

    // pending result
    logic [1:0]         r_status, n_status;
    logic               r_gshared, n_gshared;
    logic [PW-1:0]      r_gidx, n_gidx;

    // output register
    logic               r_ovalid, n_ovalid;
    logic [15:0]        r_odata, n_odata;

    // flag banks and wrap unit
    t_flag_cmd          w_pool_cmd, w_small_cmd;
    logic [PW-1:0]      w_pool_addr;
    logic               w_pool_busy, w_small_busy;
    logic               w_sock_ok, w_pidx_ok;
    logic [PW:0]        w_wrap_in, w_wrap_out;
    logic               w_wrap_ge;
    logic [COUNT_W-1:0] w_cfg_use;

    assign w_sock_ok = (int'(r_sock) < SOCKETS);
    assign w_pidx_ok = (int'(r_pidx) < POOL_DEPTH);

    // one pool address: the freed handle during exec, else the search position
    assign w_pool_addr = (r_state == ST_EXEC) ? PW'(r_pidx) : r_cand[PW-1:0];
    assign w_wrap_in   = (r_state == ST_SEARCH) ? (r_cand + 1'b1) : r_cand;

    sba_pool_flags #(
        .POOL_DEPTH (POOL_DEPTH),
        .PW         (PW)
    ) u_pool (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_addr  (w_pool_addr),
        .i_cmd   (w_pool_cmd),
        .o_busy  (w_pool_busy)
    );

    sba_small_flags #(
        .SOCKETS (SOCKETS),
        .SW      (SW)
    ) u_small (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_addr  (SW'(r_sock)),
        .i_dir   (r_dir),
        .i_cmd   (w_small_cmd),
        .o_busy  (w_small_busy)
    );

    sba_wrap #(
        .VW (PW + 1)
    ) u_wrap (
        .i_val (w_wrap_in),
        .i_mod (r_in_use),
        .o_val (w_wrap_out),
        .o_ge  (w_wrap_ge)
    );

    // clamp of a written in-use count
    always_comb begin
        w_cfg_use = i_cfg_data[COUNT_W-1:0];
        if (w_cfg_use == '0) begin
            w_cfg_use = COUNT_W'(1);
        end else if (w_cfg_use > MAX_USE_W) begin
            w_cfg_use = MAX_USE_W;
        end
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_in_use    = r_in_use;
        n_limit     = r_limit;
        n_free      = r_free;
        n_sp        = r_sp;
        n_cand      = r_cand;
        n_iter      = r_iter;
        n_status    = r_status;
        n_gshared   = r_gshared;
        n_gidx      = r_gidx;
        n_ovalid    = r_ovalid;
        n_odata     = r_odata;
        w_pool_cmd  = '0;
        w_small_cmd = '0;

        if (r_ovalid && m_axis_tready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_status  = STAT_ALREADY;
                n_gshared = 1'b0;
                n_gidx    = '0;
                n_state   = ST_RESP;
                if (r_mode == MODE_ALLOC) begin
                    n_status = STAT_NONE;
                    if (w_sock_ok && !w_small_busy && (r_size <= r_limit)) begin
                        w_small_cmd = '{we: 1'b1, val: 1'b1};
                        n_status    = STAT_OK;
                    end else if (r_free == '0) begin
                        // empty pool: fall back to the small buffer at any size
                        if (w_sock_ok && !w_small_busy) begin
                            w_small_cmd = '{we: 1'b1, val: 1'b1};
                            n_status    = STAT_OK;
                        end
                    end else begin
                        n_cand  = {1'b0, r_sp} + 1'b1;
                        n_iter  = '0;
                        n_state = ST_NORM;
                    end
                end else if (r_shared) begin
                    if (w_pidx_ok && w_pool_busy) begin
                        w_pool_cmd = '{we: 1'b1, val: 1'b0};
                        if (r_free < r_in_use) begin
                            n_free = r_free + 1'b1;
                        end
                        n_status = STAT_OK;
                    end
                end else if (w_sock_ok && w_small_busy) begin
                    w_small_cmd = '{we: 1'b1, val: 1'b0};
                    n_status    = STAT_OK;
                end
            end
            ST_NORM: begin
                // bring the first candidate below the in-use count
                if (w_wrap_ge) begin
                    n_cand = w_wrap_out;
                end else begin
                    n_state = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                n_sp = r_cand[PW-1:0];
                if (!w_pool_busy) begin
                    w_pool_cmd = '{we: 1'b1, val: 1'b1};
                    n_free     = r_free - 1'b1;
                    n_status   = STAT_OK;
                    n_gshared  = 1'b1;
                    n_gidx     = r_cand[PW-1:0];
                    n_state    = ST_RESP;
                end else if (r_iter == (r_in_use - 1'b1)) begin
                    n_state = ST_RESP;
                end else begin
                    n_cand = w_wrap_out;
                    n_iter = r_iter + 1'b1;
                end
            end
            ST_RESP: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_ovalid = 1'b1;
                    n_odata  = {2'b00, r_free, 5'(r_gidx), r_gshared, r_status};
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // configuration writes must arrive only while idle; the block does not enforce it
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_POOL_IN_USE: begin
                    n_in_use = w_cfg_use;
                    n_free   = w_cfg_use;
                end
                CFG_SMALL_LIMIT: begin
                    n_limit = i_cfg_data;
                end
                default: begin
                    n_limit = r_limit;
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_in_use <= RESET_USE_W;
            r_limit  <= SIZE_W'(512);
            r_free   <= RESET_USE_W;
            r_sp     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_in_use <= n_in_use;
            r_limit  <= n_limit;
            r_free   <= n_free;
            r_sp     <= n_sp;
            r_ovalid <= n_ovalid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_mode   <= s_axis_tuser[0];
            r_sock   <= s_axis_tdata[3:0];
            r_dir    <= s_axis_tdata[4];
            r_size   <= s_axis_tdata[20:5];
            r_shared <= s_axis_tdata[21];
            r_pidx   <= s_axis_tdata[26:22];
        end
        r_cand    <= n_cand;
        r_iter    <= n_iter;
        r_status  <= n_status;
        r_gshared <= n_gshared;
        r_gidx    <= n_gidx;
        r_odata   <= n_odata;
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

`include "socket_buffer_allocator_top_macros.svh"

    `SBA_ASSERT_NOW(a_free_bound, i_clk, i_rst_n, 1'b1, r_free <= r_in_use)
    `SBA_ASSERT_NEXT(a_accept_exec, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, r_state == ST_EXEC)
    `SBA_ASSERT_NOW(a_cand_range, i_clk, i_rst_n, r_state == ST_SEARCH, int'(r_cand) < int'(r_in_use))
    `SBA_ASSERT_NOW(a_grant_ok, i_clk, i_rst_n, r_ovalid && r_odata[2], r_odata[1:0] == STAT_OK)

endmodule
